>>> sv/rmts_pkg.sv
// -----------------------------------------------------------------------------
// rmts_pkg
// Types, constants and helpers shared by the rate-monotonic tick scheduler.
// -----------------------------------------------------------------------------
package rmts_pkg;

   localparam int MAX_TASKS = 8;
   localparam int SLOT_BITS = $clog2(MAX_TASKS);
   localparam int TIME_BITS = 32;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_TICK = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_IDLE     = 3'd0,
      EV_CONTINUE = 3'd1,
      EV_START    = 3'd2,
      EV_RESUME   = 3'd3,
      EV_PREEMPT  = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      ALU_RUN  = 2'd0,
      ALU_MISS = 2'd1,
      ALU_WAIT = 2'd2
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVT,
      ST_RUN,
      ST_MISS,
      ST_WAIT,
      ST_CHK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  slot;
      logic [7:0]  task_id;
      logic [15:0] exec_time;
      logic [15:0] period;
      logic [15:0] repetitions;
   } req_type;

   typedef struct packed {
      logic               ran;
      logic [2:0]         run_slot;
      logic [7:0]         run_task_id;
      logic [2:0]         event_res;
      logic [2:0]         prev_slot;
      logic               finished;
      logic [7:0]         miss_mask;
      logic               all_done;
      logic [31:0]        current_time;
      logic [15:0]        stat_completed;
      logic [15:0]        stat_missed;
      logic signed [31:0] stat_waiting;
   } rsp_type;

   typedef struct packed {
      logic [7:0]           id;
      logic [15:0]          exec;
      logic [15:0]          period;
      logic [15:0]          jobs;
      logic [15:0]          rem;
      logic [TIME_BITS-1:0] rel;
      logic [TIME_BITS-1:0] dl;
      logic [15:0]          missed;
      logic [15:0]          done;
      logic signed [31:0]   wait_total;
   } slot_type;

   typedef struct packed {
      slot_type           entry;
      logic               flag;
      logic signed [33:0] spent;
   } alu_res_type;

   function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] a,
                                                 input logic [15:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {{(TIME_BITS-15){1'b0}}, b};
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

   function automatic logic [15:0] cinc(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   function automatic logic signed [31:0] wsat(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -36'sh0_8000_0000) r = -32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> sv/rmts_slot_table.sv
// -----------------------------------------------------------------------------
// rmts_slot_table
// Per-slot task state: one read port and one write port.
// -----------------------------------------------------------------------------
module rmts_slot_table import rmts_pkg::*; (
   input  logic                 clock,
   input  logic [SLOT_BITS-1:0] rd_idx,
   output slot_type             rd_entry,
   input  logic                 wr_en,
   input  logic [SLOT_BITS-1:0] wr_idx,
   input  slot_type             wr_entry
);

   slot_type slots_ff [MAX_TASKS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_entry = slots_ff[rd_idx];

endmodule

>>> sv/rmts_slot_alu.sv
// -----------------------------------------------------------------------------
// rmts_slot_alu
// Shared slot update unit: run one unit, miss check, waiting update.
// -----------------------------------------------------------------------------
module rmts_slot_alu import rmts_pkg::*; (
   input  alu_op_type           op,
   input  slot_type             entry_in,
   input  logic [TIME_BITS-1:0] t,
   input  logic signed [33:0]   spent_in,
   input  logic                 miss_in,
   input  logic                 is_run_slot,
   output alu_res_type          res
);

   slot_type           e;
   logic [15:0]        rem_d;
   logic [TIME_BITS:0] t_plus_r;
   logic signed [35:0] sum1;
   logic signed [35:0] sum2;
   logic signed [31:0] w1;

   always_comb begin
      e        = entry_in;
      res.flag = 1'b0;
      res.spent = '0;
      rem_d    = (entry_in.rem != 16'd0) ? entry_in.rem - 16'd1 : 16'd0;
      t_plus_r = {1'b0, t} + {{(TIME_BITS-15){1'b0}}, entry_in.rem};
      sum1     = {{4{entry_in.wait_total[31]}}, entry_in.wait_total}
                 - {{2{spent_in[33]}}, spent_in}
                 + $signed({20'd0, entry_in.period});
      w1       = miss_in ? wsat(sum1) : entry_in.wait_total;
      sum2     = {{4{w1[31]}}, w1} + 36'sd1;
      case (op)
         ALU_RUN: begin
            e.rem = rem_d;
            if (rem_d == 16'd0) begin
               e.done = cinc(entry_in.done);
               e.rel  = tadd(entry_in.rel, entry_in.period);
               e.dl   = tadd(entry_in.dl, entry_in.period);
               e.rem  = entry_in.exec;
               if (entry_in.jobs != 16'd0) e.jobs = entry_in.jobs - 16'd1;
               res.flag = 1'b1;
            end
         end
         ALU_MISS: begin
            if (entry_in.jobs != 16'd0 && {1'b0, entry_in.dl} <= t_plus_r) begin
               res.spent = $signed({2'b00, t}) - $signed({2'b00, entry_in.rel})
                           - $signed({18'd0, entry_in.exec - entry_in.rem});
               e.missed = cinc(entry_in.missed);
               e.rel    = tadd(entry_in.rel, entry_in.period);
               e.dl     = tadd(entry_in.dl, entry_in.period);
               e.rem    = entry_in.exec;
               e.jobs   = entry_in.jobs - 16'd1;
               res.flag = 1'b1;
            end
         end
         ALU_WAIT: begin
            e.wait_total = w1;
            if (!is_run_slot && entry_in.rel <= t && entry_in.jobs != 16'd0) begin
               e.wait_total = wsat(sum2);
            end
            res.flag = (entry_in.jobs != 16'd0);
         end
         default: begin
            e = entry_in;
         end
      endcase
      res.entry = e;
   end

endmodule

>>> sv/rate_monotonic_tick_scheduler_core.sv
// Throughput: one item at a time; slots are visited one after another, and the
// run, miss and waiting updates go through the shared slot update unit.
// Synchronous active-high reset clears time, task count and scheduler
// history; slot contents stay undefined.
// -----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_core
// Rate-monotonic tick scheduler with a sequenced slot scan.
// -----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_core import rmts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);

   state_type            state_ff, state_in;
   logic [SLOT_BITS:0]   idx_ff, idx_in;
   logic [3:0]           tc_ff;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic                 last_valid_ff, last_valid_in;
   logic [SLOT_BITS-1:0] last_slot_ff, last_slot_in;
   logic                 was_running_ff, was_running_in;
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] best_slot_ff, best_slot_in;
   logic [15:0]          best_per_ff, best_per_in;
   logic [7:0]           best_id_ff, best_id_in;
   logic                 last_partial_ff, last_partial_in;
   logic                 miss_ff, miss_in;
   logic signed [33:0]   spent_ff, spent_in;
   logic                 done_acc_ff, done_acc_in;
   rsp_type              rsp_ff, rsp_in;

   logic [SLOT_BITS:0]   n_act;
   logic [SLOT_BITS-1:0] rd_idx;
   slot_type             rd_entry;
   logic                 wr_en;
   logic [SLOT_BITS-1:0] wr_idx;
   slot_type             wr_entry;
   alu_op_type           alu_op;
   alu_res_type          alu_res;
   slot_type             load_entry;
   logic                 in_range;

   assign n_act    = (tc_ff > MAX_TASKS) ? (SLOT_BITS+1)'(MAX_TASKS) : (SLOT_BITS+1)'(tc_ff);
   assign in_range = idx_ff < n_act;

   rmts_slot_table u_table (
      .clock    (clock),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry)
   );

   rmts_slot_alu u_alu (
      .op          (alu_op),
      .entry_in    (rd_entry),
      .t           (tick_ff),
      .spent_in    (spent_ff),
      .miss_in     (miss_ff),
      .is_run_slot (idx_ff[SLOT_BITS-1:0] == best_slot_ff),
      .res         (alu_res)
   );

   always_comb begin
      load_entry.id         = req_data.task_id;
      load_entry.exec       = req_data.exec_time;
      load_entry.period     = req_data.period;
      load_entry.jobs       = req_data.repetitions;
      load_entry.rem        = req_data.exec_time;
      load_entry.rel        = tick_ff;
      load_entry.dl         = tadd(tick_ff, req_data.period);
      load_entry.missed     = '0;
      load_entry.done       = '0;
      load_entry.wait_total = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tc_ff          <= '0;
         tick_ff        <= '0;
         last_valid_ff  <= 1'b0;
         last_slot_ff   <= '0;
         was_running_ff <= 1'b1;
      end else begin
         state_ff       <= state_in;
         tick_ff        <= tick_in;
         last_valid_ff  <= last_valid_in;
         last_slot_ff   <= last_slot_in;
         was_running_ff <= was_running_in;
         if (csr_write_enable) tc_ff <= csr_write_data;
      end
      idx_ff          <= idx_in;
      found_ff        <= found_in;
      best_slot_ff    <= best_slot_in;
      best_per_ff     <= best_per_in;
      best_id_ff      <= best_id_in;
      last_partial_ff <= last_partial_in;
      miss_ff         <= miss_in;
      spent_ff        <= spent_in;
      done_acc_ff     <= done_acc_in;
      rsp_ff          <= rsp_in;
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      tick_in         = tick_ff;
      last_valid_in   = last_valid_ff;
      last_slot_in    = last_slot_ff;
      was_running_in  = was_running_ff;
      found_in        = found_ff;
      best_slot_in    = best_slot_ff;
      best_per_in     = best_per_ff;
      best_id_in      = best_id_ff;
      last_partial_in = last_partial_ff;
      miss_in         = miss_ff;
      spent_in        = spent_ff;
      done_acc_in     = done_acc_ff;
      rsp_in          = rsp_ff;
      rd_idx          = idx_ff[SLOT_BITS-1:0];
      wr_en           = 1'b0;
      wr_idx          = idx_ff[SLOT_BITS-1:0];
      wr_entry        = alu_res.entry;
      alu_op          = ALU_RUN;
      req_stall       = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_OUT);

      case (state_ff)
         ST_IDLE: begin
            rd_idx = req_data.slot;
            if (req_valid) begin
               rsp_in              = '0;
               rsp_in.current_time = tick_ff;
               idx_in              = '0;
               done_acc_in         = 1'b1;
               found_in            = 1'b0;
               case (req_data.cmd)
                  CMD_LOAD: begin
                     wr_en    = 1'b1;
                     wr_idx   = req_data.slot;
                     wr_entry = load_entry;
                     state_in = ST_CHK;
                  end
                  CMD_READ: begin
                     rsp_in.stat_completed = rd_entry.done;
                     rsp_in.stat_missed    = rd_entry.missed;
                     rsp_in.stat_waiting   = rd_entry.wait_total;
                     state_in              = ST_CHK;
                  end
                  CMD_TICK: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (in_range) begin
               if (rd_entry.rel <= tick_ff && rd_entry.jobs != 16'd0 &&
                   (!found_ff || rd_entry.period < best_per_ff ||
                    (rd_entry.period == best_per_ff && rd_entry.id < best_id_ff))) begin
                  found_in     = 1'b1;
                  best_slot_in = idx_ff[SLOT_BITS-1:0];
                  best_per_in  = rd_entry.period;
                  best_id_in   = rd_entry.id;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = '0;
               if (found_ff) begin
                  state_in = ST_EVT;
               end else begin
                  was_running_in = 1'b0;
                  tick_in        = tadd(tick_ff, 16'd1);
                  state_in       = ST_CHK;
               end
            end
         end
         ST_EVT: begin
            rd_idx          = last_slot_ff;
            last_partial_in = (rd_entry.rem != rd_entry.exec);
            state_in        = ST_RUN;
         end
         ST_RUN: begin
            rd_idx = best_slot_ff;
            alu_op = ALU_RUN;
            wr_en  = 1'b1;
            wr_idx = best_slot_ff;
            rsp_in.ran         = 1'b1;
            rsp_in.run_slot    = best_slot_ff;
            rsp_in.run_task_id = rd_entry.id;
            rsp_in.finished    = alu_res.flag;
            if (!last_valid_ff || !was_running_ff) begin
               rsp_in.event_res = EV_START;
            end else if (last_slot_ff == best_slot_ff) begin
               rsp_in.event_res = EV_CONTINUE;
            end else if (last_partial_ff) begin
               rsp_in.event_res = EV_PREEMPT;
               rsp_in.prev_slot = last_slot_ff;
            end else if (rd_entry.rem == rd_entry.exec) begin
               rsp_in.event_res = EV_START;
            end else begin
               rsp_in.event_res = EV_RESUME;
            end
            last_valid_in  = 1'b1;
            last_slot_in   = best_slot_ff;
            was_running_in = 1'b1;
            state_in       = ST_MISS;
         end
         ST_MISS: begin
            alu_op = ALU_MISS;
            if (in_range) begin
               wr_en    = 1'b1;
               miss_in  = alu_res.flag;
               spent_in = alu_res.spent;
               state_in = ST_WAIT;
            end else begin
               rsp_in.all_done = done_acc_ff;
               tick_in         = tadd(tick_ff, 16'd1);
               state_in        = ST_OUT;
            end
         end
         ST_WAIT: begin
            alu_op = ALU_WAIT;
            wr_en  = 1'b1;
            if (alu_res.flag) done_acc_in = 1'b0;
            if (miss_ff) rsp_in.miss_mask[idx_ff[SLOT_BITS-1:0]] = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_MISS;
         end
         ST_CHK: begin
            if (in_range) begin
               if (rd_entry.jobs != 16'd0) done_acc_in = 1'b0;
               idx_in = idx_ff + 1'b1;
            end else begin
               rsp_in.all_done = done_acc_ff;
               state_in        = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

>>> test/tb_rate_monotonic_tick_scheduler_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_rate_monotonic_tick_scheduler_core
// Drives load, tick and read beats into the scheduler core and compares every
// result beat against a cycle-free rate-monotonic predictor kept in a
// scoreboard class. Task count is changed between phases while the core is
// idle. Sender bursts and receiver stalls are random.
// -----------------------------------------------------------------------------
module tb_rate_monotonic_tick_scheduler_core;
   import rmts_pkg::*;

   class sched_scoreboard;
      logic [7:0]  id [8];
      logic [15:0] exec [8];
      logic [15:0] per [8];
      logic [15:0] jobs [8];
      logic [15:0] rem [8];
      logic [31:0] rel [8];
      logic [31:0] dl [8];
      logic [15:0] missed [8];
      logic [15:0] done [8];
      longint      wtot [8];
      logic [31:0] now;
      bit          last_ok;
      int          last_slot;
      bit          was_run;
      int          tcount;
      rsp_type     pending [$];
      int          errors;
      int          checked;

      function new();
         now = 0; last_ok = 0; last_slot = 0; was_run = 1; tcount = 0;
         errors = 0; checked = 0;
         for (int i = 0; i < 8; i++) begin
            id[i] = 0; exec[i] = 0; per[i] = 0; jobs[i] = 0; rem[i] = 0;
            rel[i] = 0; dl[i] = 0; missed[i] = 0; done[i] = 0; wtot[i] = 0;
         end
      endfunction

      function logic [31:0] time_add(logic [31:0] a, logic [31:0] b);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function logic [15:0] count_inc(logic [15:0] c);
         return (c == 16'hFFFF) ? c : c + 16'd1;
      endfunction

      function longint wait_clamp(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function int active();
         return tcount > 8 ? 8 : tcount;
      endfunction

      function bit none_left();
         for (int i = 0; i < active(); i++)
            if (jobs[i] != 0) return 0;
         return 1;
      endfunction

      function void advance_job(int i);
         dl[i] = time_add(dl[i], per[i]);
         rel[i] = time_add(rel[i], per[i]);
         rem[i] = exec[i];
         if (jobs[i] != 0) jobs[i]--;
      endfunction

      function void note_req(req_type r);
         rsp_type o;
         int p;
         bit found;
         logic [31:0] t;
         logic [7:0] mask;
         longint spent;
         o = '0;
         o.current_time = now;
         if (r.cmd == CMD_NONE) return;
         if (r.cmd == CMD_LOAD) begin
            id[r.slot] = r.task_id; exec[r.slot] = r.exec_time; per[r.slot] = r.period;
            jobs[r.slot] = r.repetitions; rem[r.slot] = r.exec_time;
            rel[r.slot] = now; dl[r.slot] = time_add(now, r.period);
            missed[r.slot] = 0; done[r.slot] = 0; wtot[r.slot] = 0;
            o.all_done = none_left();
         end else if (r.cmd == CMD_READ) begin
            o.stat_completed = done[r.slot];
            o.stat_missed = missed[r.slot];
            o.stat_waiting = wtot[r.slot][31:0];
            o.all_done = none_left();
         end else begin
            t = now; found = 0; p = 0; mask = 0;
            for (int i = 0; i < active(); i++) begin
               if (rel[i] > t || jobs[i] == 0) continue;
               if (!found || per[i] < per[p] || (per[i] == per[p] && id[i] < id[p])) begin
                  p = i; found = 1;
               end
            end
            if (!found) begin
               was_run = 0;
               now = time_add(t, 1);
               o.all_done = none_left();
            end else begin
               if (!last_ok || !was_run) o.event_res = EV_START;
               else if (last_slot == p) o.event_res = EV_CONTINUE;
               else if (rem[last_slot] == exec[last_slot])
                  o.event_res = (rem[p] == exec[p]) ? EV_START : EV_RESUME;
               else begin
                  o.event_res = EV_PREEMPT;
                  o.prev_slot = last_slot[2:0];
               end
               o.ran = 1; o.run_slot = p[2:0]; o.run_task_id = id[p];
               if (rem[p] != 0) rem[p]--;
               if (rem[p] == 0) begin
                  done[p] = count_inc(done[p]);
                  advance_job(p);
                  o.finished = 1;
               end
               last_ok = 1; last_slot = p; was_run = 1;
               for (int i = 0; i < active(); i++) begin
                  if (jobs[i] != 0 && (dl[i] <= t || dl[i] - t <= {16'd0, rem[i]})) begin
                     spent = longint'({32'd0, t}) - longint'({32'd0, rel[i]})
                             - longint'(exec[i] - rem[i]);
                     missed[i] = count_inc(missed[i]);
                     wtot[i] = wait_clamp(wtot[i] - spent + longint'(per[i]));
                     advance_job(i);
                     mask[i] = 1'b1;
                  end
               end
               for (int i = 0; i < active(); i++)
                  if (i != p && rel[i] <= t && jobs[i] != 0)
                     wtot[i] = wait_clamp(wtot[i] + 1);
               o.miss_mask = mask;
               o.all_done = none_left();
               now = time_add(t, 1);
            end
         end
         pending.insert(pending.size(), o);
      endfunction

      function void check_rsp(rsp_type a);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %p", a);
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 0;
   logic [3:0] csr_write_data = 0;

   sched_scoreboard board = new();
   bit          loaded [8];
   int          stall_mode = 0;
   int          beats_sent = 0;

   rate_monotonic_tick_scheduler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_req(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_rsp(rsp_data);
   end

   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   task automatic send(req_type r);
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_count(logic [3:0] v);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      board.tcount = v;
      @(posedge clock);
   endtask

   function automatic req_type make_load(int s, logic [7:0] tid, logic [15:0] ex,
                                         logic [15:0] pr, logic [15:0] rp);
      req_type r;
      r.cmd = CMD_LOAD; r.slot = 3'(s); r.task_id = tid; r.exec_time = ex;
      r.period = pr; r.repetitions = rp;
      return r;
   endfunction

   function automatic req_type make_cmd(cmd_type c, int s);
      req_type r;
      r = '0;
      r.cmd = c; r.slot = 3'(s);
      r.task_id = 8'($urandom); r.exec_time = 16'($urandom); r.period = 16'($urandom);
      r.repetitions = 16'($urandom);
      return r;
   endfunction

   task automatic random_item();
      int k;
      int s;
      req_type r;
      k = $urandom_range(0, 99);
      s = $urandom_range(0, 7);
      if (k < 15) begin
         if ($urandom_range(0, 9) == 0)
            r = make_load(s, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         else
            r = make_load(s, 8'($urandom), 16'($urandom_range(0, 4)),
                          16'($urandom_range(1, 12)), 16'($urandom_range(0, 6)));
         loaded[s] = 1;
      end else if (k < 25) begin
         while (!loaded[s]) s = $urandom_range(0, 7);
         r = make_cmd(CMD_READ, s);
      end else if (k < 28) begin
         r = make_cmd(CMD_NONE, s);
      end else begin
         r = make_cmd(CMD_TICK, s);
      end
      send(r);
   endtask

   initial begin
      int burst;
      int phase_cnt [5] = '{8, 3, 15, 1, 0};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         send(make_load(i, 8'(255 - i), 16'(i % 3), (i < 4) ? 16'd3 : 16'd5, 16'd3));
         loaded[i] = 1;
      end
      send(make_cmd(CMD_TICK, 0));
      set_count(4'd8);
      for (int i = 0; i < 6; i++) send(make_cmd(CMD_TICK, i));
      send(make_load(0, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(make_load(1, 8'h00, 16'd1, 16'hFFFF, 16'd1));
      send(make_load(2, 8'hAA, 16'd2, 16'd1, 16'd2));
      for (int i = 0; i < 4; i++) send(make_cmd(CMD_TICK, 0));
      send(make_cmd(CMD_READ, 0));
      send(make_cmd(CMD_READ, 2));
      send(make_cmd(CMD_NONE, 7));
      send(make_cmd(CMD_READ, 7));
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         set_count(4'(phase_cnt[ph]));
         stall_mode = ph % 3;
         for (int n = 0; n < 180; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               random_item();
               n++;
            end
            if ($urandom_range(0, 3) != 0) gap();
         end
      end
      drain();
      $display("Sent %0d beats, checked %0d results over task counts 0 to 15.",
               beats_sent, board.checked);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> filelist.f
sv/rmts_pkg.sv
sv/rmts_slot_table.sv
sv/rmts_slot_alu.sv
sv/rate_monotonic_tick_scheduler_core.sv
test/tb_rate_monotonic_tick_scheduler_core.sv
